// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                      cmd;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] removed_value;
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] head_value;
      logic [COUNT_W-1:0]        count;
      logic                      is_empty;
   } rsp_type;

   // Broadcast to every cell in the row.
   typedef struct packed {
      logic                      ins;
      logic                      rem;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: a row of compare-and-shift cells.
// The result item is registered and appears in the cycle after the command is taken.
// Throughput: one command per cycle; busy stays low, since every cell
// compares and shifts in the same cycle the command arrives.
// Reset clears the count and the result strobe; cell contents stay undefined
// and are never reported until written. The receiver cannot stall results.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_item,
   output logic             rsp_strobe,
   output spq_pkg::rsp_type rsp_item
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   cell_ctl_type              ctl;
   logic                      accept;
   logic                      full;
   logic                      empty;
   logic                      ins_ok;
   logic                      rem_ok;
   logic [CNT_W+COUNT_W-1:0]  count_ext;

   logic                      cell_le    [QUEUE_DEPTH];
   logic signed [VALUE_W-1:0] cell_value [QUEUE_DEPTH];
   logic signed [VALUE_W-1:0] cell_next  [QUEUE_DEPTH];

   // Queue is never stalled: every cycle can take a command.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign ins_ok = accept && (req_item.cmd == CMD_INSERT) && !full;
   assign rem_ok = accept && (req_item.cmd == CMD_REMOVE) && !empty;

   assign ctl.ins   = ins_ok;
   assign ctl.rem   = rem_ok;
   assign ctl.value = req_item.value;

   // The row. Cell i is valid when i < count. An insert lands in the first
   // cell that is empty or whose entry is greater than the new value (left_le of cell 0 is
   // tied high), and everything behind it moves one slot right. A remove
   // moves every entry one slot left; the last cell recirculates its own.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      logic                      valid;
      logic                      left_le;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;

      assign valid = (IDX < count_ff);

      if (i == 0) begin : g_first
         assign left_le    = 1'b1;
         assign left_value = req_item.value;
      end else begin : g_inner
         assign left_le    = cell_le[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .valid       (valid),
         .left_le     (left_le),
         .left_value  (left_value),
         .right_value (right_value),
         .le_out      (cell_le[i]),
         .value_out   (cell_value[i]),
         .value_next  (cell_next[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rem_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Reported count is the low bits of the count after the step.
   assign count_ext = {{COUNT_W{1'b0}}, count_in};

   // Result is built from the next state so it reflects the queue after the step.
   always_comb begin
      rsp_in.removed_value = rem_ok ? cell_value[0] : '0;
      rsp_in.status        = ST_OK;
      if (accept && (req_item.cmd == CMD_INSERT) && full) begin
         rsp_in.status = ST_FULL;
      end else if (accept && (req_item.cmd == CMD_REMOVE) && empty) begin
         rsp_in.status = ST_EMPTY;
      end
      rsp_in.head_value = (count_in != '0) ? cell_next[0] : '0;
      rsp_in.count      = count_ext[COUNT_W-1:0];
      rsp_in.is_empty   = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted row: holds an entry, shifts left or right, or takes the new value.
module spq_cell (
   input  logic                               clock,
   input  spq_pkg::cell_ctl_type              ctl,
   input  logic                               valid,
   input  logic                               left_le,
   input  logic signed [spq_pkg::VALUE_W-1:0] left_value,
   input  logic signed [spq_pkg::VALUE_W-1:0] right_value,
   output logic                               le_out,
   output logic signed [spq_pkg::VALUE_W-1:0] value_out,
   output logic signed [spq_pkg::VALUE_W-1:0] value_next
);
   import spq_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   // Stored entry is <= new value: it stays ahead of the insertion point.
   assign le_out    = valid && (entry_ff <= ctl.value);
   assign value_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (!le_out) begin
            entry_in = left_le ? ctl.value : left_value;
         end
      end else if (ctl.rem) begin
         entry_in = right_value;
      end
   end

   assign value_next = entry_in;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for sorted_priority_queue: directed and random command traffic.
module tb_top;
   import spq_pkg::*;

   localparam int DEPTH        = DEFAULT_QUEUE_DEPTH;
   // Cycles with no accepted command and no result before the run is declared hung.
   localparam int STALL_LIMIT  = 2000;
   // Settling time after the last result, plus margin.
   localparam int DRAIN_CYCLES = 4;

   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   sorted_priority_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predicted queue contents, kept in ascending order.
   // ---------------------------------------------------------------------
   logic signed [VALUE_W-1:0] sorted_vals [DEPTH];
   int          stored_count    = 0;
   rsp_type     reports_due [$];      // expected result items, oldest first
   int unsigned error_count     = 0;
   int unsigned sender_idle_pct = 0;  // chance (percent) the sender skips a cycle
   int          stall_cycles    = 0;

   // Apply one command to the predicted queue and return the result item it causes.
   function automatic rsp_type apply_queue_op(input req_type op);
      rsp_type r;
      int      pos;
      r        = '0;
      r.status = ST_OK;
      if (op.cmd == CMD_INSERT) begin
         if (stored_count >= DEPTH) begin
            r.status = ST_FULL;        // dropped, queue untouched
         end else begin
            // new value lands after every stored value <= it, so ties keep arrival order
            pos = 0;
            while (pos < stored_count && sorted_vals[pos] <= op.value) pos++;
            for (int i = stored_count; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
            sorted_vals[pos] = op.value;
            stored_count++;
         end
      end else begin
         if (stored_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.removed_value = sorted_vals[0];
            for (int i = 1; i < stored_count; i++) sorted_vals[i-1] = sorted_vals[i];
            stored_count--;
         end
      end
      r.head_value = (stored_count > 0) ? sorted_vals[0] : '0;
      r.count      = COUNT_W'(stored_count);
      r.is_empty   = (stored_count == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
      error_count++;
   endtask

   // Random value: ties near zero, edges of the signed range, or anything.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(4))
         0:       return $urandom_range(6) - 3;
         1:       return VAL_MAX - $urandom_range(3);
         2:       return VAL_MIN + $urandom_range(3);
         default: return $urandom();
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Send one command item. Drives at the rising edge; the item counts as
   // taken at the first edge with start high and busy low. start is only
   // dropped on idle cycles, so back-to-back items keep it high.
   // ---------------------------------------------------------------------
   task automatic send_item(input logic cmd, input logic signed [VALUE_W-1:0] value);
      req_type op;
      op.cmd   = cmd;
      op.value = value;
      while ($urandom_range(99) < sender_idle_pct) begin
         start    <= 1'b0;
         req_item <= req_type'({1'($urandom_range(1)), $urandom()});  // junk while idle
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= op;
      do @(posedge clock); while (busy);
      reports_due.push_back(apply_queue_op(op));
   endtask

   // ---------------------------------------------------------------------
   // Result checker: every strobe pairs with the oldest expected item.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type due;
      if (!reset && rsp_strobe) begin
         if (reports_due.size() == 0) begin
            report_mismatch("result with nothing due", rsp_item.head_value, '0);
         end else begin
            due = reports_due.pop_front();
            if (rsp_item.removed_value !== due.removed_value)
               report_mismatch("removed_value", rsp_item.removed_value, due.removed_value);
            if (rsp_item.status !== due.status)
               report_mismatch("status", VALUE_W'(rsp_item.status), VALUE_W'(due.status));
            if (rsp_item.head_value !== due.head_value)
               report_mismatch("head_value", rsp_item.head_value, due.head_value);
            if (rsp_item.count !== due.count)
               report_mismatch("count", VALUE_W'(rsp_item.count), VALUE_W'(due.count));
            if (rsp_item.is_empty !== due.is_empty)
               report_mismatch("is_empty", VALUE_W'(rsp_item.is_empty),
                               VALUE_W'(due.is_empty));
         end
      end
   end

   // Hang guard: counts cycles in which nothing moves in either direction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Remove from empty, signed extremes, equal values, drain back to empty.
   task automatic test_empty_and_extremes();
      sender_idle_pct = 0;
      send_item(CMD_REMOVE, VAL_MAX);   // empty: status empty, value ignored
      send_item(CMD_INSERT, 0);
      send_item(CMD_INSERT, 0);         // tie goes behind the first zero
      send_item(CMD_INSERT, VAL_MAX);
      send_item(CMD_INSERT, VAL_MIN);   // new head
      send_item(CMD_INSERT, -1);
      send_item(CMD_INSERT, 1);
      repeat (6) send_item(CMD_REMOVE, VAL_MIN);
      send_item(CMD_REMOVE, 0);         // empty again
      send_item(CMD_INSERT, VAL_MAX);
      send_item(CMD_INSERT, VAL_MAX);
      send_item(CMD_INSERT, VAL_MIN);
      repeat (4) send_item(CMD_REMOVE, -1);
   endtask

   // Fill to capacity, push inserts that must be dropped, then drain past empty.
   task automatic test_full_queue();
      sender_idle_pct = 0;
      while (stored_count > 0) send_item(CMD_REMOVE, pick_value());
      while (stored_count < DEPTH) send_item(CMD_INSERT, $urandom_range(15) - 8);
      send_item(CMD_INSERT, VAL_MIN);   // smaller than head, still dropped
      send_item(CMD_INSERT, pick_value());
      repeat (DEPTH + 1) send_item(CMD_REMOVE, pick_value());
   endtask

   // Bursts of inserts, bursts of removes and mixed runs, so the queue
   // keeps swinging between empty and full.
   task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct);
      int unsigned sent;
      int unsigned burst;
      int unsigned mode;
      logic        cmd;
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 20);
         mode  = $urandom_range(2);
         repeat (burst) begin
            case (mode)
               0:       cmd = CMD_INSERT;
               1:       cmd = CMD_REMOVE;
               default: cmd = ($urandom_range(1) == 0) ? CMD_INSERT : CMD_REMOVE;
            endcase
            send_item(cmd, pick_value());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_extremes();
      test_full_queue();
      test_random_traffic(300, 32);
      test_random_traffic(300, 78);
      test_random_traffic(300, 0);

      start <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
